// File: hdl/trq_pkg.sv
// Shared types and constants for the thread ready queue.
// Request codes, status codes, state encoding and default sizes.
package trq_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int TRQ_MAX_ENTRIES = 16;
    localparam int TRQ_ID_BITS     = 8;
    localparam int TRQ_PRIO_BITS   = 8;

    // Queue limit register
    localparam int          LIMIT_W     = 5;
    localparam logic [4:0]  LIMIT_RESET = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_SORTED = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_WALK     = 6'b000010,
        ST_TAIL_WR  = 6'b000100,
        ST_HEAD_RD  = 6'b001000,
        ST_HEAD_CAP = 6'b010000,
        ST_OUT      = 6'b100000
    } trq_state_t;

endpackage

// File: hdl/thread_ready_queue_unit.sv
// Thread ready queue: bounded ordered queue of (id, priority) entries.
// Entry memory with one write port and one read port, walked by a small sequencer. Depends on trq_pkg.

// A request transaction on the s_ channel yields exactly one result transaction
// on the m_ channel. The block takes one request at a time: s_tready is high
// only while it is idle, and stays low until the result has been taken.
// Entries live in a MAX_ENTRIES-deep memory with one write port and one
// registered read port; the sequencer walks it one entry per cycle, reading
// entry i+1 while it writes entry i (or i-1). Sorted push, pop and remove
// walk every stored entry; a push at the tail, a rejected push and a pop or
// remove on an empty queue do not. A result is held until m_tready takes it.
// The queue limit comes in on the cfg_ channel (always ready) and should be
// changed only while no request is in flight; a limit above MAX_ENTRIES acts
// as MAX_ENTRIES, and zero makes every push report full. There is no clearing
// pass: only entries below the occupancy count are ever used.
module thread_ready_queue_unit #(
    parameter int MAX_ENTRIES = trq_pkg::TRQ_MAX_ENTRIES,
    parameter int ID_BITS     = trq_pkg::TRQ_ID_BITS,
    parameter int PRIO_BITS   = trq_pkg::TRQ_PRIO_BITS,
    // derived widths, not meant to be overridden
    parameter int CNT_W  = $clog2(MAX_ENTRIES + 1),
    parameter int IN_TW  = ((2 + ID_BITS + PRIO_BITS + 7) / 8) * 8,
    parameter int OUT_TW = ((2 + 2 * ID_BITS + PRIO_BITS + 1 + CNT_W + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata, low bit up: req_type, thread_id, prio_in, zero fill
    input  logic [IN_TW-1:0]             s_tdata,
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata, low bit up: status, taken_id, taken_priority, head_valid,
    // head_id, entry_count, zero fill
    output logic [OUT_TW-1:0]            m_tdata,
    // queue limit write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [trq_pkg::LIMIT_W-1:0]  cfg_data
);
    import trq_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int ENT_W = ID_BITS + PRIO_BITS;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // entry memory: {prio, id}
    logic [ENT_W-1:0] mem [MAX_ENTRIES];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data_reg;

    trq_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [1:0]           op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [ENT_W-1:0]     hold_reg, hold_next;    // entry carried toward the tail
    logic                 flag_reg, flag_next;    // inserted / found so far
    logic [1:0]           status_reg, status_next;
    logic [ENT_W-1:0]     taken_reg, taken_next;
    logic [ID_BITS-1:0]   head_id_reg, head_id_next;

    // unpacked request
    logic [1:0]           in_req;
    logic [ID_BITS-1:0]   in_id;
    logic [PRIO_BITS-1:0] in_prio;

    logic                 full;
    logic [CNT_W-1:0]     idx_p1, idx_m1;
    logic                 last;
    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 match;

    assign in_req  = s_tdata[1:0];
    assign in_id   = s_tdata[2 +: ID_BITS];
    assign in_prio = s_tdata[2 + ID_BITS +: PRIO_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;

    assign m_tdata = OUT_TW'({count_reg, head_id_reg, (count_reg != '0),
                              taken_reg[ID_BITS +: PRIO_BITS],
                              taken_reg[ID_BITS-1:0], status_reg});

    // full against the configured limit and against the capacity
    assign full = (CMP_W'(count_reg) >= CMP_W'(limit_reg)) ||
                  (CMP_W'(count_reg) >= CMP_W'(MAX_ENTRIES));

    assign idx_p1  = idx_reg + CNT_W'(1);
    assign idx_m1  = idx_reg - CNT_W'(1);
    assign last    = (idx_p1 == count_reg);
    assign rd_id   = rd_data_reg[ID_BITS-1:0];
    assign rd_prio = rd_data_reg[ID_BITS +: PRIO_BITS];
    // pop takes slot 0, remove takes the first id hit
    assign match   = (op_reg == REQ_POP) ? (idx_reg == '0) : (rd_id == id_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        prio_next    = prio_reg;
        hold_next    = hold_reg;
        flag_next    = flag_reg;
        status_next  = status_reg;
        taken_next   = taken_reg;
        head_id_next = head_id_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[IDX_W-1:0];
        wr_data      = hold_reg;
        rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_req;
                    id_next     = in_id;
                    prio_next   = in_prio;
                    hold_next   = {in_prio, in_id};
                    flag_next   = 1'b0;
                    idx_next    = '0;
                    status_next = STAT_OK;
                    taken_next  = '0;
                    rd_addr     = '0;
                    if (in_req == REQ_PUSH || in_req == REQ_SORTED) begin
                        if (full) begin
                            status_next = STAT_FULL;
                            state_next  = ST_HEAD_RD;
                        end else if (in_req == REQ_SORTED && count_reg != '0) begin
                            state_next = ST_WALK;
                        end else begin
                            state_next = ST_TAIL_WR;
                        end
                    end else if (count_reg == '0) begin
                        status_next = STAT_EMPTY;
                        state_next  = ST_HEAD_RD;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                // rd_data_reg holds entry idx_reg; fetch the next one
                rd_addr = idx_p1[IDX_W-1:0];
                if (op_reg == REQ_SORTED) begin
                    // from the first entry with a higher priority value on,
                    // every entry moves back one slot
                    if (flag_reg || (prio_reg < rd_prio)) begin
                        wr_en     = 1'b1;
                        wr_addr   = idx_reg[IDX_W-1:0];
                        wr_data   = hold_reg;
                        hold_next = rd_data_reg;
                        flag_next = 1'b1;
                    end
                end else begin
                    if (flag_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = idx_m1[IDX_W-1:0];
                        wr_data = rd_data_reg;
                    end else if (match) begin
                        flag_next  = 1'b1;
                        taken_next = rd_data_reg;
                    end
                end
                idx_next = idx_p1;
                if (last) begin
                    if (op_reg == REQ_SORTED) begin
                        state_next = ST_TAIL_WR;
                    end else begin
                        if (flag_reg || match) begin
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            status_next = STAT_NOTFOUND;
                        end
                        state_next = ST_HEAD_RD;
                    end
                end
            end

            ST_TAIL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                wr_data    = hold_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_HEAD_RD;
            end

            ST_HEAD_RD: begin
                rd_addr    = '0;
                state_next = ST_HEAD_CAP;
            end

            ST_HEAD_CAP: begin
                head_id_next = (count_reg != '0) ? rd_id : '0;
                state_next   = ST_OUT;
            end

            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        id_reg      <= id_next;
        prio_reg    <= prio_next;
        hold_reg    <= hold_next;
        flag_reg    <= flag_next;
        status_reg  <= status_next;
        taken_reg   <= taken_next;
        head_id_reg <= head_id_next;
    end

endmodule
